@@ hw/rtl/merit_ordered_record_cache_macros.svh @@
// assertion macros for the merit ordered record cache
`ifndef MERIT_ORDERED_RECORD_CACHE_MACROS_SVH
`define MERIT_ORDERED_RECORD_CACHE_MACROS_SVH

// same-cycle implication
`define MORC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("morc assertion failed");

// next-cycle implication
`define MORC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("morc assertion failed");

`endif

@@ hw/rtl/morc_pkg.sv @@
`default_nettype none
package morc_pkg;

  localparam logic [31:0] TOP_MERIT = 32'hFFFF_FFFF;
  localparam logic [6:0]  CAP_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_SAVE   = 2'd0,
    OP_FETCH  = 2'd1,
    OP_REMOVE = 2'd2,
    OP_FLUSH  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PEEK,
    ST_SCAN_UP,
    ST_SCAN_DN,
    ST_FIND,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] merit;
    logic [31:0] handle;
  } entry_t;

endpackage
`default_nettype wire

@@ hw/rtl/merit_ordered_record_cache.sv @@
// flush and zero-merit saves skip the table; a full-cache save is rejected if slot 0 has higher merit
// a save walks the sorted table from the top down (or from the bottom up when it evicts)
// fetch and remove walk from slot 0 until a match, remove shifting the tail down behind it
// one request at a time: in_ready is high only while idle, until the last result is registered
// reset: synchronous active low, clears control, occupancy and sets capacity to 64
// the entry memory is not cleared; only slots below the occupancy are ever read
`default_nettype none
module merit_ordered_record_cache
  import morc_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_operation,
  input  wire logic [31:0] in_record_id,
  input  wire logic [31:0] in_sub_count,
  input  wire logic [31:0] in_record_handle,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_hit,
  output logic [31:0]      out_handle_out,
  output logic             out_accepted,
  output logic             out_evicted,
  output logic [6:0]       out_occupancy,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [6:0]  cfg_capacity
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t mem [DEPTH];
  entry_t rd_q;

  state_t        state_r, state_nxt;
  op_t           op_r, op_nxt;
  logic [31:0]   id_r, id_nxt;
  logic [31:0]   merit_r, merit_nxt;
  logic [31:0]   hdl_r, hdl_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [6:0]    cap_r;
  logic          found_r, found_nxt;
  logic          acc_r, acc_nxt;
  logic          ev_r, ev_nxt;
  logic          pv_r;
  logic [AW-1:0] pa_r;

  logic          out_valid_r, out_valid_nxt;
  logic          out_hit_r, out_hit_nxt;
  logic [31:0]   out_hout_r, out_hout_nxt;
  logic          out_acc_r, out_acc_nxt;
  logic          out_ev_r, out_ev_nxt;
  logic [6:0]    out_occ_r, out_occ_nxt;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  entry_t        new_entry;

  logic [31:0]   in_merit;
  logic [6:0]    cap_w;
  logic          full;

  assign in_merit  = (in_record_id == 32'd0) ? TOP_MERIT : in_sub_count;
  assign cap_w     = (cap_r == 7'd0) ? 7'd1 : cap_r;
  assign full      = (cnt_r >= CW'(DEPTH)) || (32'(cnt_r) >= 32'(cap_w));
  assign new_entry = '{id: id_r, merit: merit_r, handle: hdl_r};

  assign in_ready       = (state_r == ST_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_handle_out = out_hout_r;
  assign out_accepted   = out_acc_r;
  assign out_evicted    = out_ev_r;
  assign out_occupancy  = out_occ_r;

  // entry memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      cap_r       <= CAP_RESET;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pv_r        <= rd_en;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) cap_r <= cfg_capacity;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    merit_r    <= merit_nxt;
    hdl_r      <= hdl_nxt;
    idx_r      <= idx_nxt;
    found_r    <= found_nxt;
    acc_r      <= acc_nxt;
    ev_r       <= ev_nxt;
    pa_r       <= rd_addr;
    out_hit_r  <= out_hit_nxt;
    out_hout_r <= out_hout_nxt;
    out_acc_r  <= out_acc_nxt;
    out_ev_r   <= out_ev_nxt;
    out_occ_r  <= out_occ_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    id_nxt        = id_r;
    merit_nxt     = merit_r;
    hdl_nxt       = hdl_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    found_nxt     = found_r;
    acc_nxt       = acc_r;
    ev_nxt        = ev_r;
    rd_en         = 1'b0;
    rd_addr       = idx_r[AW-1:0];
    wr_en         = 1'b0;
    wr_addr       = pa_r;
    wr_data       = rd_q;
    out_valid_nxt = out_valid_r && !out_ready;
    out_hit_nxt   = out_hit_r;
    out_hout_nxt  = out_hout_r;
    out_acc_nxt   = out_acc_r;
    out_ev_nxt    = out_ev_r;
    out_occ_nxt   = out_occ_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = op_t'(in_operation);
          id_nxt    = in_record_id;
          merit_nxt = in_merit;
          hdl_nxt   = in_record_handle;
          found_nxt = 1'b0;
          acc_nxt   = 1'b0;
          ev_nxt    = 1'b0;
          idx_nxt   = '0;
          unique case (op_t'(in_operation))
            OP_SAVE: begin
              if (in_merit == 32'd0) begin
                state_nxt = ST_DONE;
              end else if (full) begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                state_nxt = ST_PEEK;
              end else begin
                idx_nxt   = cnt_r;
                state_nxt = ST_SCAN_DN;
              end
            end
            OP_FETCH, OP_REMOVE: begin
              hdl_nxt   = '0;
              state_nxt = ST_FIND;
            end
            OP_FLUSH: begin
              hdl_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = ST_DONE;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end

      // slot 0 holds the lowest merit
      ST_PEEK: begin
        if (merit_r < rd_q.merit) begin
          state_nxt = ST_DONE;
        end else begin
          ev_nxt    = 1'b1;
          idx_nxt   = CW'(1);
          state_nxt = ST_SCAN_UP;
        end
      end

      // evict slot 0: shift entries down until the new merit fits
      ST_SCAN_UP: begin
        if (pv_r) begin
          wr_en   = 1'b1;
          wr_addr = pa_r - AW'(1);
          if (rd_q.merit > merit_r) begin
            wr_data   = new_entry;
            acc_nxt   = 1'b1;
            state_nxt = ST_DONE;
          end
        end else if (idx_r == cnt_r) begin
          wr_en     = 1'b1;
          wr_addr   = AW'(cnt_r - CW'(1));
          wr_data   = new_entry;
          acc_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end
        if (idx_r < cnt_r) begin
          rd_en   = 1'b1;
          rd_addr = idx_r[AW-1:0];
          idx_nxt = idx_r + CW'(1);
        end
      end

      // room left: shift larger merits up from the top
      ST_SCAN_DN: begin
        if (pv_r) begin
          wr_en   = 1'b1;
          wr_addr = pa_r + AW'(1);
          if (rd_q.merit <= merit_r) begin
            wr_data   = new_entry;
            acc_nxt   = 1'b1;
            cnt_nxt   = cnt_r + CW'(1);
            state_nxt = ST_DONE;
          end
        end else if (idx_r == '0) begin
          wr_en     = 1'b1;
          wr_addr   = '0;
          wr_data   = new_entry;
          acc_nxt   = 1'b1;
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = ST_DONE;
        end
        if (idx_r != '0) begin
          rd_en   = 1'b1;
          rd_addr = AW'(idx_r - CW'(1));
          idx_nxt = idx_r - CW'(1);
        end
      end

      // first match in merit order, remove closes the gap behind it
      ST_FIND: begin
        if (pv_r) begin
          if (!found_r) begin
            if (rd_q.id == id_r) begin
              found_nxt = 1'b1;
              if (op_r == OP_FETCH) begin
                hdl_nxt   = rd_q.handle;
                state_nxt = ST_DONE;
              end
            end
          end else begin
            wr_en   = 1'b1;
            wr_addr = pa_r - AW'(1);
          end
        end else if (idx_r == cnt_r) begin
          if (found_r) cnt_nxt = cnt_r - CW'(1);
          state_nxt = ST_DONE;
        end
        if (idx_r < cnt_r) begin
          rd_en   = 1'b1;
          rd_addr = idx_r[AW-1:0];
          idx_nxt = idx_r + CW'(1);
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = found_r;
          out_hout_nxt  = (op_r == OP_FETCH) ? hdl_r : 32'd0;
          out_acc_nxt   = acc_r;
          out_ev_nxt    = ev_r;
          out_occ_nxt   = 7'(cnt_r);
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/morc_checker.sv @@
`default_nettype none
`include "merit_ordered_record_cache_macros.svh"
module morc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_hit,
  input wire logic [31:0] out_handle_out,
  input wire logic        out_accepted,
  input wire logic        out_evicted
);

  logic [34:0] out_beat;

  assign out_beat = {out_hit, out_handle_out, out_accepted, out_evicted};

  // a stalled result beat holds
  `MORC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_beat))

  `MORC_ASSERT_IMP(a_hit_not_save, clk, rst_n, out_valid && out_hit, !out_accepted && !out_evicted)

  `MORC_ASSERT_IMP(a_evict_stores, clk, rst_n, out_valid && out_evicted, out_accepted)

  `MORC_ASSERT_IMP(a_miss_zero, clk, rst_n, out_valid && !out_hit, out_handle_out == 32'd0)

endmodule

bind merit_ordered_record_cache morc_checker u_morc_checker (.*);
`default_nettype wire
